[hw/rtl/edcs_pkg.sv]
// shared types and constants for the elevator car dispatch selector
`timescale 1ns / 1ps
`default_nettype none

package edcs_pkg;

   // field widths of the stream items
   localparam int FLOOR_W     = 5;
   localparam int LOAD_W      = 8;
   localparam int CAR_FIELD_W = 2;

   // car index width inside the chain, wide enough for the largest car count
   localparam int CAR_IDX_W = 4;

   // default size of the car group
   localparam int NUM_CARS_DEF = 4;

   // reset values of the car table and the registers, and the load saturation value
   localparam logic [FLOOR_W-1:0] FLOOR_RESET   = FLOOR_W'(1);
   localparam logic [LOAD_W-1:0]  MAX_CAP_RESET = LOAD_W'(8);
   localparam logic [LOAD_W-1:0]  LOAD_SAT      = '1;

   typedef enum logic [1:0] {
      MOT_IDLE = 2'd0,
      MOT_UP   = 2'd1,
      MOT_DOWN = 2'd2,
      MOT_STOP = 2'd3
   } motion_type;

   typedef enum logic [1:0] {
      STRAT_NEAREST = 2'd0,
      STRAT_SCAN    = 2'd1,
      STRAT_LOOK    = 2'd2
   } strategy_type;

   typedef enum logic [0:0] {
      CSR_STRATEGY = 1'b0,
      CSR_MAX_CAP  = 1'b1
   } csr_index_type;

   typedef enum logic [0:0] {
      REQ_STATUS   = 1'b0,
      REQ_DISPATCH = 1'b1
   } req_kind_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_FINISH
   } ctrl_state_type;

   // request payload, first field in the lowest bits
   typedef struct packed {
      logic [4:0]         pad;
      logic [FLOOR_W-1:0] target_floor;
      logic [FLOOR_W-1:0] source_floor;
      logic [LOAD_W-1:0]  car_load;
      logic [1:0]         car_motion;
      logic [FLOOR_W-1:0] car_floor;
      logic [CAR_FIELD_W-1:0] car_index;
   } req_data_type;

   // response payload, first field in the lowest bits
   typedef struct packed {
      logic [3:0]             pad;
      logic [1:0]             chosen_motion;
      logic [CAR_FIELD_W-1:0] chosen_car;
   } rsp_data_type;

   // configuration seen by every cell
   typedef struct packed {
      logic [1:0]        strategy;
      logic [LOAD_W-1:0] max_cap;
   } cfg_type;

   // broadcast command from the controller to the cells
   typedef struct packed {
      logic                 wr_en;
      logic                 upd_en;
      logic [CAR_IDX_W-1:0] idx;
      logic [FLOOR_W-1:0]   floor;
      motion_type           motion;
      logic [LOAD_W-1:0]    load;
      logic                 dir_up;
   } cell_cmd_type;

   // best candidate found so far
   typedef struct packed {
      logic                 found;
      logic [CAR_IDX_W-1:0] idx;
      logic [FLOOR_W-1:0]   span;
      motion_type           mot;
   } best_type;

   // search token passed from cell to cell
   typedef struct packed {
      logic               valid;
      logic [FLOOR_W-1:0] src;
      logic [FLOOR_W-1:0] tgt;
      best_type           s_best;
      best_type           n_best;
   } token_type;

endpackage

`default_nettype wire

[hw/rtl/edcs_cell.sv]
// one car of the chain: car status plus one stage of the search token
`timescale 1ns / 1ps
`default_nettype none

module edcs_cell
   import edcs_pkg::*;
#(
   parameter int CELL_IDX = 0
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire cfg_type      cfg,
   input  wire cell_cmd_type cmd,
   input  wire token_type    tok_in,
   output token_type         tok_out
);

   localparam logic [CAR_IDX_W-1:0] MY_IDX = CAR_IDX_W'(CELL_IDX);

   logic [FLOOR_W-1:0] floor_ff, floor_in;
   motion_type         motion_ff, motion_in;
   logic [LOAD_W-1:0]  load_ff, load_in;
   token_type          tok_ff, tok_in_next;

   logic [FLOOR_W-1:0] span;
   logic               avail;
   logic               moving;
   logic               look_ok;
   logic               strat_ok;
   logic               s_take;
   logic               n_take;
   logic               hit;

   // candidate qualification for this car
   always_comb begin
      span     = (floor_ff >= tok_in.src) ? (floor_ff - tok_in.src) : (tok_in.src - floor_ff);
      avail    = (load_ff < cfg.max_cap) &&
                 ((motion_ff == MOT_IDLE) ||
                  ((motion_ff == MOT_UP) && (tok_in.tgt > floor_ff)) ||
                  ((motion_ff == MOT_DOWN) && (tok_in.tgt < floor_ff)));
      moving   = (motion_ff == MOT_UP) || (motion_ff == MOT_DOWN);
      look_ok  = ((motion_ff == MOT_UP) && (tok_in.src >= floor_ff)) ||
                 ((motion_ff == MOT_DOWN) && (tok_in.src <= floor_ff));
      strat_ok = ((cfg.strategy == STRAT_SCAN) && moving) ||
                 ((cfg.strategy == STRAT_LOOK) && look_ok);
      s_take   = avail && strat_ok &&
                 (!tok_in.s_best.found || (span < tok_in.s_best.span));
      n_take   = avail && (!tok_in.n_best.found || (span < tok_in.n_best.span));
   end

   // token update, strict less-than keeps the lowest index on ties
   always_comb begin
      tok_in_next = tok_in;
      if (s_take) begin
         tok_in_next.s_best.found = 1'b1;
         tok_in_next.s_best.idx   = MY_IDX;
         tok_in_next.s_best.span  = span;
         tok_in_next.s_best.mot   = motion_ff;
      end
      if (n_take) begin
         tok_in_next.n_best.found = 1'b1;
         tok_in_next.n_best.idx   = MY_IDX;
         tok_in_next.n_best.span  = span;
         tok_in_next.n_best.mot   = motion_ff;
      end
   end

   // token stage, payload held until the next token arrives
   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.valid <= 1'b0;
      end else if (tok_in.valid) begin
         tok_ff <= tok_in_next;
      end else begin
         tok_ff.valid <= 1'b0;
      end
   end

   assign tok_out = tok_ff;

   // car status: status write or assignment update
   always_comb begin
      hit       = (cmd.idx == MY_IDX);
      floor_in  = floor_ff;
      motion_in = motion_ff;
      load_in   = load_ff;
      if (cmd.wr_en && hit) begin
         floor_in  = cmd.floor;
         motion_in = cmd.motion;
         load_in   = cmd.load;
      end else if (cmd.upd_en && hit) begin
         if (load_ff != LOAD_SAT) begin
            load_in = load_ff + LOAD_W'(1);
         end
         if (motion_ff == MOT_IDLE) begin
            motion_in = cmd.dir_up ? MOT_UP : MOT_DOWN;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         floor_ff  <= FLOOR_RESET;
         motion_ff <= MOT_IDLE;
         load_ff   <= '0;
      end else begin
         floor_ff  <= floor_in;
         motion_ff <= motion_in;
         load_ff   <= load_in;
      end
   end

endmodule

`default_nettype wire

[hw/rtl/edcs_ctrl.sv]
// controller: registers, request intake, token launch and result commit
`timescale 1ns / 1ps
`default_nettype none

module edcs_ctrl
   import edcs_pkg::*;
#(
   parameter int NUM_CARS = NUM_CARS_DEF
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [31:0]  req_tdata,
   input  wire logic         req_tuser,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [7:0]        rsp_tdata,
   output logic              rsp_tuser,
   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic [0:0]   csr_index,
   input  wire logic [7:0]   csr_data,
   output cfg_type           cfg,
   output cell_cmd_type      cmd,
   output token_type         tok_first,
   input  wire token_type    tok_last
);

   ctrl_state_type state_ff, state_in;
   cfg_type        cfg_ff, cfg_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           rsp_assigned_ff, rsp_assigned_in;
   rsp_data_type   rsp_data_ff, rsp_data_in;

   req_data_type   req_data;
   logic           req_accept;
   logic           out_free;
   logic           commit;
   logic           use_s;
   best_type       best;
   logic           dir_up;

   assign req_data   = req_data_type'(req_tdata);
   assign req_accept = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign csr_ready  = 1'b1;
   assign cfg        = cfg_ff;

   // register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_STRATEGY: cfg_in.strategy = csr_data[1:0];
            CSR_MAX_CAP:  cfg_in.max_cap  = csr_data;
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept && (req_tuser == REQ_DISPATCH)) begin
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            if (tok_last.valid) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // choice from the token that left the last cell
   always_comb begin
      use_s  = ((cfg_ff.strategy == STRAT_SCAN) || (cfg_ff.strategy == STRAT_LOOK)) &&
               tok_last.s_best.found;
      best   = use_s ? tok_last.s_best : tok_last.n_best;
      dir_up = (tok_last.tgt > tok_last.src);
   end

   // outputs of the state machine
   always_comb begin
      req_tready = 1'b0;
      commit     = 1'b0;
      unique case (state_ff)
         ST_IDLE:   req_tready = 1'b1;
         ST_WALK:   req_tready = 1'b0;
         ST_FINISH: commit     = out_free;
         default:   req_tready = 1'b0;
      endcase

      // token launched into the first cell
      tok_first        = '0;
      tok_first.valid  = req_accept && (req_tuser == REQ_DISPATCH);
      tok_first.src    = req_data.source_floor;
      tok_first.tgt    = req_data.target_floor;

      // broadcast to the cells: status write or assignment update
      cmd        = '0;
      cmd.dir_up = dir_up;
      if (commit) begin
         cmd.upd_en = best.found;
         cmd.idx    = best.idx;
      end else begin
         cmd.wr_en  = req_accept && (req_tuser == REQ_STATUS) &&
                      (32'(req_data.car_index) < NUM_CARS);
         cmd.idx    = CAR_IDX_W'(req_data.car_index);
         cmd.floor  = req_data.car_floor;
         cmd.motion = motion_type'(req_data.car_motion);
         cmd.load   = req_data.car_load;
      end
   end

   // output register
   always_comb begin
      rsp_valid_in    = rsp_valid_ff && !rsp_tready;
      rsp_assigned_in = rsp_assigned_ff;
      rsp_data_in     = rsp_data_ff;
      if (commit) begin
         rsp_valid_in    = 1'b1;
         rsp_assigned_in = best.found;
         rsp_data_in     = '0;
         if (best.found) begin
            rsp_data_in.chosen_car    = best.idx[CAR_FIELD_W-1:0];
            rsp_data_in.chosen_motion = (best.mot == MOT_IDLE) ?
                                        (dir_up ? MOT_UP : MOT_DOWN) : best.mot;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         cfg_ff.strategy  <= STRAT_NEAREST;
         cfg_ff.max_cap   <= MAX_CAP_RESET;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         cfg_ff           <= cfg_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_assigned_ff <= rsp_assigned_in;
      rsp_data_ff     <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_assigned_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire

[hw/rtl/elevator_car_dispatch_selector.sv]
// top level: controller and a chain of car cells
//
// channel  direction  handshake             payload
// req      in         req_tvalid/tready     tdata car/request fields, tuser kind
// rsp      out        rsp_tvalid/tready     tdata chosen car/motion, tuser assigned
// csr      in         csr_valid/ready       csr_index, csr_data
//
// a status write goes straight into the addressed car cell; a dispatch launches the
// search token, which walks one car cell per cycle, and then commits the result.
// the commit waits while the output register still holds an untaken result.
// reset is synchronous, restores all cars to floor 1, idle, empty, and the
// registers to nearest-car strategy with capacity 8.
`timescale 1ns / 1ps
`default_nettype none

module elevator_car_dispatch_selector
   import edcs_pkg::*;
#(
   parameter int NUM_CARS = NUM_CARS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // tdata: car_index, car_floor, car_motion, car_load, source_floor,
   //        target_floor, zero pad
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,
   // tuser: req_type
   input  wire logic        req_tuser,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // tdata: chosen_car, chosen_motion, zero pad
   output logic [7:0]       rsp_tdata,
   // tuser: assigned
   output logic             rsp_tuser,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [0:0]  csr_index,
   input  wire logic [7:0]  csr_data
);

   cfg_type      cfg;
   cell_cmd_type cmd;
   token_type    tok_chain [NUM_CARS+1];

   // control, registers and output stage
   edcs_ctrl #(
      .NUM_CARS (NUM_CARS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .cfg        (cfg),
      .cmd        (cmd),
      .tok_first  (tok_chain[0]),
      .tok_last   (tok_chain[NUM_CARS])
   );

   // one cell per car, token flows from car 0 upwards
   for (genvar i = 0; i < NUM_CARS; i++) begin : g_cell
      edcs_cell #(
         .CELL_IDX (i)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .cfg     (cfg),
         .cmd     (cmd),
         .tok_in  (tok_chain[i]),
         .tok_out (tok_chain[i+1])
      );
   end

`ifndef NO_ASSERTIONS
   // no search token leaves the chain while requests are taken
   a_idle_no_token: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !tok_chain[NUM_CARS].valid)
      else $error("search token at chain end while idle");

   // a dispatch blocks intake on the following cycle
   a_dispatch_busy: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && (req_tuser == REQ_DISPATCH)) |=> !req_tready)
      else $error("request taken during a dispatch");

   // an unassigned result carries zero fields
   a_none_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |-> (rsp_tdata == '0))
      else $error("unassigned result with nonzero fields");

   // status writes and assignment updates never coincide
   a_cmd_excl: assert property (@(posedge clock) disable iff (reset)
      !(cmd.wr_en && cmd.upd_en))
      else $error("status write and update in the same cycle");
`endif

endmodule

`default_nettype wire
